>>> hw/rtl/mvsc_pkg.sv
// shared types and widths for the midi value sign converter
// no dependencies; used by the divider cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package mvsc_pkg;

    // divider geometry: dividend bits, divisor bits, signed result bits
    localparam int NUM_W = 34;
    localparam int DIV_W = 17;
    localparam int RES_W = 35;

    // sign mode codes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_TWOS   = 2'd1;
    localparam logic [1:0] MODE_SIGNMAG = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_SIGN_MODE  = 3'd0;
    localparam logic [2:0] REG_BIT_WIDTH  = 3'd1;
    localparam logic [2:0] REG_VALUE_LOW  = 3'd2;
    localparam logic [2:0] REG_VALUE_HIGH = 3'd3;
    localparam logic [2:0] REG_MIDI_LOW   = 3'd4;
    localparam logic [2:0] REG_MIDI_HIGH  = 3'd5;

    // per-item sideband that rides along the pipeline
    typedef struct packed {
        logic                    cmd;  // 1 decode, 0 encode
        logic                    lin;  // result comes from the divider
        logic                    clp;  // clamp the final result
        logic                    neg;  // quotient is negated
        logic signed [RES_W-1:0] pre;  // result when not from the divider
    } t_side;

endpackage

`default_nettype wire

>>> hw/rtl/midi_value_sign_converter_unit.sv
// top level of the midi value sign converter: config registers, operand
// stages, divider cell chain and output register; depends on mvsc_pkg, mvsc_div_cell
`timescale 1ns / 1ps
`default_nettype none

// Converts one item per clock, back to back, between a signed display value
// and a MIDI wire value. From input transfer to output valid an item passes
// through 38 register stages: an operand stage (loaded at the transfer
// edge), a multiply stage, a numerator stage, a chain of 34 divider cells (one
// quotient bit each) and the output register. The whole pipeline stalls
// together only while a finished result waits on the output.
// Configuration writes are always ready and must only be made while idle.
module midi_value_sign_converter_unit import mvsc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic signed [15:0] i_value_in,
    input  wire logic        [15:0] i_midi_in,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic             [15:0] o_midi_out,
    output logic signed      [15:0] o_value_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic         [2:0] i_cfg_index,
    input  wire logic        [15:0] i_cfg_data
);

    localparam int NCELL = NUM_W;

    // configuration registers
    logic        [1:0]  r_sign_mode;
    logic        [3:0]  r_bit_width;
    logic signed [15:0] r_value_low;
    logic signed [15:0] r_value_high;
    logic        [13:0] r_midi_low;
    logic        [13:0] r_midi_high;

    logic w_adv;
    logic w_in_xfer;

    assign o_cfg_ready = 1'b1;
    assign w_adv       = !(o_valid && i_stall);
    assign o_stall     = !w_adv;
    assign w_in_xfer   = i_valid && w_adv;

    // config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign_mode  <= MODE_LINEAR;
            r_bit_width  <= 4'd7;
            r_value_low  <= 16'sd0;
            r_value_high <= 16'sd127;
            r_midi_low   <= 14'd0;
            r_midi_high  <= 14'd127;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIGN_MODE:  r_sign_mode  <= i_cfg_data[1:0];
                REG_BIT_WIDTH:  r_bit_width  <= i_cfg_data[3:0];
                REG_VALUE_LOW:  r_value_low  <= i_cfg_data;
                REG_VALUE_HIGH: r_value_high <= i_cfg_data;
                REG_MIDI_LOW:   r_midi_low   <= i_cfg_data[13:0];
                REG_MIDI_HIGH:  r_midi_high  <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // operand stage logic
    logic signed [17:0] w_range;
    logic signed [17:0] w_half;
    logic signed [17:0] w_v18;
    logic signed [17:0] w_m18;
    logic signed [17:0] w_mlo18;
    logic signed [17:0] w_mhi18;
    logic signed [17:0] w_vlo18;
    logic signed [17:0] w_vhi18;
    logic signed [17:0] w_mclamp;
    logic signed [17:0] w_direct;
    logic               w_linmode;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dout;
    logic signed [16:0] w_olo;
    logic signed [16:0] w_den;

    always_comb begin
        w_range   = 18'sd1 <<< r_bit_width;
        w_half    = w_range >>> 1;
        w_v18     = 18'(i_value_in);
        w_m18     = $signed({2'b00, i_midi_in});
        w_mlo18   = $signed({4'b0000, r_midi_low});
        w_mhi18   = $signed({4'b0000, r_midi_high});
        w_vlo18   = 18'(r_value_low);
        w_vhi18   = 18'(r_value_high);
        w_linmode = !(r_sign_mode == MODE_TWOS || r_sign_mode == MODE_SIGNMAG);
        // midi input clamp, low end checked first
        if (w_m18 < w_mlo18) begin
            w_mclamp = w_mlo18;
        end else if (w_m18 > w_mhi18) begin
            w_mclamp = w_mhi18;
        end else begin
            w_mclamp = w_m18;
        end
        // sign modes
        if (!i_command) begin
            if (w_v18 < 0) begin
                w_direct = (r_sign_mode == MODE_TWOS) ? w_range + w_v18 : w_half - w_v18;
            end else begin
                w_direct = w_v18;
            end
        end else begin
            if (w_m18 >= w_half) begin
                w_direct = (r_sign_mode == MODE_TWOS) ? w_m18 - w_range : w_half - w_m18;
            end else begin
                w_direct = w_m18;
            end
        end
        // linear map operands
        if (!i_command) begin
            w_dx   = 17'(w_v18 - w_vlo18);
            w_dout = 17'(w_mhi18 - w_mlo18);
            w_olo  = 17'(w_mlo18);
            w_den  = 17'(w_vhi18 - w_vlo18);
        end else begin
            w_dx   = 17'(w_mclamp - w_mlo18);
            w_dout = 17'(w_vhi18 - w_vlo18);
            w_olo  = 17'(w_vlo18);
            w_den  = 17'(w_mhi18 - w_mlo18);
        end
    end

    // stage a: operands
    logic               r_a_valid;
    t_side              r_a_side;
    logic signed [16:0] r_a_dx;
    logic signed [16:0] r_a_dout;
    logic signed [16:0] r_a_olo;
    logic signed [16:0] r_a_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_side.cmd <= i_command;
            r_a_side.lin <= w_linmode;
            r_a_side.clp <= i_command || w_linmode;
            r_a_side.neg <= 1'b0;
            r_a_side.pre <= RES_W'(w_direct);
            r_a_dx       <= w_dx;
            r_a_dout     <= w_dout;
            r_a_olo      <= w_olo;
            r_a_den      <= w_den;
        end
    end

    // stage b: products
    logic               r_b_valid;
    t_side              r_b_side;
    logic signed [33:0] r_b_p1;
    logic signed [33:0] r_b_p2;
    logic signed [16:0] r_b_olo;
    logic signed [16:0] r_b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_side <= r_a_side;
            r_b_p1   <= r_a_dx * r_a_dout;
            r_b_p2   <= r_a_olo * r_a_den;
            r_b_olo  <= r_a_olo;
            r_b_den  <= r_a_den;
        end
    end

    // stage c: numerator sign fold and divider operands
    logic signed [RES_W-1:0] w_num;
    logic signed [RES_W-1:0] w_numf;
    logic        [RES_W-1:0] w_anum;
    logic        [16:0]      w_aden;
    logic                    w_den0;
    t_side                   w_c_side;

    always_comb begin
        w_num  = RES_W'(r_b_p1) + RES_W'(r_b_p2);
        w_numf = (r_b_den < 0) ? -w_num : w_num;
        w_anum = (w_numf < 0) ? $unsigned(-w_numf) : $unsigned(w_numf);
        w_aden = (r_b_den < 0) ? $unsigned(-r_b_den) : $unsigned(r_b_den);
        w_den0 = (r_b_den == 17'sd0);
        w_c_side     = r_b_side;
        w_c_side.neg = w_numf < 0;
        if (r_b_side.lin && w_den0) begin
            w_c_side.lin = 1'b0;
            w_c_side.pre = RES_W'(r_b_olo);
        end
    end

    logic               r_c_valid;
    t_side              r_c_side;
    logic [NUM_W-1:0]   r_c_num;
    logic [DIV_W-1:0]   r_c_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_side <= w_c_side;
            r_c_num  <= NUM_W'({w_anum[NUM_W-2:0], 1'b0}) + NUM_W'(w_aden);
            r_c_div  <= {w_aden[DIV_W-2:0], 1'b0};
        end
    end

    // divider cell chain
    logic             w_cv   [NCELL+1];
    logic [DIV_W-1:0] w_crem [NCELL+1];
    logic [NUM_W-1:0] w_cnum [NCELL+1];
    logic [NUM_W-1:0] w_cquo [NCELL+1];
    logic [DIV_W-1:0] w_cdiv [NCELL+1];
    t_side            w_cside[NCELL+1];

    assign w_cv[0]    = r_c_valid;
    assign w_crem[0]  = '0;
    assign w_cnum[0]  = r_c_num;
    assign w_cquo[0]  = '0;
    assign w_cdiv[0]  = r_c_div;
    assign w_cside[0] = r_c_side;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        mvsc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_cv[g]),
            .i_rem   (w_crem[g]),
            .i_num   (w_cnum[g]),
            .i_quo   (w_cquo[g]),
            .i_div   (w_cdiv[g]),
            .i_side  (w_cside[g]),
            .o_valid (w_cv[g+1]),
            .o_rem   (w_crem[g+1]),
            .o_num   (w_cnum[g+1]),
            .o_quo   (w_cquo[g+1]),
            .o_div   (w_cdiv[g+1]),
            .o_side  (w_cside[g+1])
        );
    end

    // result select and clamp
    t_side                   w_fs;
    logic signed [RES_W-1:0] w_q;
    logic signed [RES_W-1:0] w_val;
    logic signed [RES_W-1:0] w_lo;
    logic signed [RES_W-1:0] w_hi;
    logic signed [RES_W-1:0] w_res;

    always_comb begin
        w_fs  = w_cside[NCELL];
        w_q   = $signed({1'b0, w_cquo[NCELL]});
        w_val = w_fs.lin ? (w_fs.neg ? -w_q : w_q) : w_fs.pre;
        w_lo  = w_fs.cmd ? RES_W'(r_value_low) : RES_W'($signed({1'b0, r_midi_low}));
        w_hi  = w_fs.cmd ? RES_W'(r_value_high) : RES_W'($signed({1'b0, r_midi_high}));
        w_res = w_val;
        if (w_fs.clp) begin
            if (w_val < w_lo) begin
                w_res = w_lo;
            end else if (w_val > w_hi) begin
                w_res = w_hi;
            end
        end
    end

    // output register
    logic        r_o_valid;
    logic [15:0] r_o_midi;
    logic [15:0] r_o_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= w_cv[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_midi  <= w_fs.cmd ? 16'd0 : w_res[15:0];
            r_o_value <= w_fs.cmd ? w_res[15:0] : 16'd0;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_midi_out  = r_o_midi;
    assign o_value_out = $signed(r_o_value);

endmodule

`default_nettype wire

>>> hw/rtl/mvsc_div_cell.sv
// one restoring divider cell: produces one quotient bit per item
// depends on mvsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvsc_div_cell import mvsc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [DIV_W-1:0] i_rem,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [NUM_W-1:0] i_quo,
    input  wire logic [DIV_W-1:0] i_div,
    input  wire t_side            i_side,
    output logic                  o_valid,
    output logic [DIV_W-1:0]      o_rem,
    output logic [NUM_W-1:0]      o_num,
    output logic [NUM_W-1:0]      o_quo,
    output logic [DIV_W-1:0]      o_div,
    output t_side                 o_side
);

    logic [DIV_W:0]   w_shift;
    logic             w_ge;
    logic [DIV_W:0]   w_diff;

    logic             r_valid;
    logic [DIV_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_div;
    t_side            r_side;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_shift = {i_rem, i_num[NUM_W-1]};
        w_ge    = w_shift >= {1'b0, i_div};
        w_diff  = w_shift - {1'b0, i_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_num  <= {i_num[NUM_W-2:0], 1'b0};
            r_quo  <= {i_quo[NUM_W-2:0], w_ge};
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

`default_nettype wire

>>> hw/rtl/mvsc_checker.sv
// port-level checks for the midi value sign converter
// depends on midi_value_sign_converter_unit (bound to it below)
`timescale 1ns / 1ps
`default_nettype none

module mvsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_stall,
    input wire logic [15:0] o_midi_out,
    input wire logic [15:0] o_value_out
);

    // only one direction carries a result
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_midi_out == 16'd0 || o_value_out == 16'd0))
        else $error("both result fields nonzero");

    // input stalls only behind a held output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // held output keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_midi_out) && $stable(o_value_out)))
        else $error("stalled result changed");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind midi_value_sign_converter_unit mvsc_checker u_mvsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_midi_out  (o_midi_out),
    .o_value_out (o_value_out)
);

`default_nettype wire

>>> dv/midi_value_sign_converter_unit_tb.sv
// testbench for the midi value sign converter: directed and random conversions
// with a scoreboard class and randomized idling; depends on mvsc_pkg and the rtl
`timescale 1ns / 1ps

module midi_value_sign_converter_unit_tb;
    import mvsc_pkg::*;

    localparam int LATENCY = 38;
    localparam int N_RANDOM = 1600;

    typedef struct {
        logic [15:0]        midi;
        logic signed [15:0] value;
    } t_conv;

    // converter settings and expected results
    class conv_scoreboard;
        logic [1:0]         mode;
        int                 width;
        int                 vlo, vhi, mlo, mhi;
        t_conv              pending[$];
        int                 errors;

        function void init();
            mode = MODE_LINEAR; width = 7; vlo = 0; vhi = 127; mlo = 0; mhi = 127;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                REG_SIGN_MODE:  mode = d[1:0];
                REG_BIT_WIDTH:  width = d[3:0];
                REG_VALUE_LOW:  vlo = $signed(d);
                REG_VALUE_HIGH: vhi = $signed(d);
                REG_MIDI_LOW:   mlo = d[13:0];
                REG_MIDI_HIGH:  mhi = d[13:0];
                default: ;
            endcase
        endfunction

        static function longint clip(longint x, longint lo, longint hi);
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        // rational map rounded half away from zero
        static function longint map_range(longint x, longint ilo, longint ihi,
                                          longint olo, longint ohi);
            longint den, num;
            den = ihi - ilo;
            if (den == 0) return olo;
            num = (x - ilo) * (ohi - olo) + olo * den;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            if (num >= 0) return (2 * num + den) / (2 * den);
            return -((2 * (-num) + den) / (2 * den));
        endfunction

        function void note_input(logic cmd, logic signed [15:0] vin, logic [15:0] min);
            longint span, half, m, v;
            t_conv  r;
            span = longint'(1) << width;
            half = span / 2;
            r.midi = '0;
            r.value = '0;
            if (!cmd) begin
                v = vin;
                if (mode == MODE_TWOS) m = (v < 0) ? span + v : v;
                else if (mode == MODE_SIGNMAG) m = (v < 0) ? half - v : v;
                else m = clip(map_range(v, vlo, vhi, mlo, mhi), mlo, mhi);
                r.midi = m[15:0];
            end else begin
                m = min;
                if (mode == MODE_TWOS) v = (m >= half) ? m - span : m;
                else if (mode == MODE_SIGNMAG) v = (m >= half) ? half - m : m;
                else begin
                    m = clip(m, mlo, mhi);
                    v = map_range(m, mlo, mhi, vlo, vhi);
                end
                v = clip(v, vlo, vhi);
                r.value = v[15:0];
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] midi, logic signed [15:0] value);
            t_conv e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result midi=%0h value=%0d", midi, value);
                return;
            end
            e = pending.pop_front();
            if (e.midi !== midi || e.value !== value) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp midi=%0h value=%0d, got midi=%0h value=%0d",
                             e.midi, e.value, midi, value);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall, i_command;
    logic signed [15:0] i_value_in;
    logic [15:0]        i_midi_in;
    logic               o_valid, i_stall;
    logic [15:0]        o_midi_out;
    logic signed [15:0] o_value_out;
    logic               i_cfg_valid, o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    conv_scoreboard sb;
    bit             hold_off;
    bit             sink_gaps;

    midi_value_sign_converter_unit u_top (.*);

    // clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_midi_out, o_value_out);
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // receiver stall, with one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (150) @(negedge i_clk);
                hold_off = 1'b0;
                i_stall <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                n = gap_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(negedge i_clk);
                    i_stall <= 1'b0;
                end
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // one register write; the caller drops valid after its last write
    task automatic cfg_write(logic [2:0] idx, logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    task automatic send_item(logic cmd, logic [15:0] vin, logic [15:0] min, bit idle);
        int n;
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_value_in <= vin;
        i_midi_in  <= min;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, vin, min);
        @(negedge i_clk);
        if (idle && $urandom_range(0, 2) == 0) begin
            n = gap_len();
            if (n > 0) begin
                i_valid <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic set_all(logic [1:0] md, logic [3:0] w, logic [15:0] vl, logic [15:0] vh,
                           logic [13:0] ml, logic [13:0] mh);
        cfg_write(REG_SIGN_MODE, {14'd0, md});
        cfg_write(REG_BIT_WIDTH, {12'd0, w});
        cfg_write(REG_VALUE_LOW, vl);
        cfg_write(REG_VALUE_HIGH, vh);
        cfg_write(REG_MIDI_LOW, {2'd0, ml});
        cfg_write(REG_MIDI_HIGH, {2'd0, mh});
        i_cfg_valid <= 1'b0;
    endtask

    // random item biased toward the configured ranges
    task automatic send_random(bit idle);
        logic [15:0] v, m;
        v = 16'($urandom);
        m = 16'($urandom);
        case ($urandom_range(0, 3))
            0: v = 16'(int'($urandom_range(0, 2 * (sb.vhi > sb.vlo ? sb.vhi - sb.vlo : 1)))
                   + sb.vlo - int'($urandom_range(0, 3)));
            1: m = 16'($urandom_range(0, (1 << sb.width) + 2));
            2: m = 16'($urandom_range(0, 16383));
            default: ;
        endcase
        send_item(1'($urandom_range(0, 1)), v, m, idle);
    endtask

    // main sequence
    initial begin
        sb = new();
        sb.init();
        i_rst_n = 1'b0; i_valid = 1'b0; i_command = 1'b0; i_value_in = '0;
        i_midi_in = '0; i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        hold_off = 1'b0; sink_gaps = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, field extremes
        send_item(1'b0, 16'h0000, 16'd0, 1'b0);
        send_item(1'b0, 16'h7fff, 16'hffff, 1'b0);
        send_item(1'b0, 16'h8000, 16'h0000, 1'b0);
        send_item(1'b1, 16'h0000, 16'hffff, 1'b0);
        send_item(1'b1, 16'hffff, 16'd64, 1'b0);
        send_item(1'b0, 16'd64, 16'd0, 1'b0);
        drain();
        // two's complement, wide and overflowing
        set_all(MODE_TWOS, 4'd15, 16'h8000, 16'h7fff, 14'd0, 14'h3fff);
        send_item(1'b0, 16'h8000, 16'd0, 1'b0);
        send_item(1'b0, 16'hffff, 16'd0, 1'b0);
        send_item(1'b1, 16'd0, 16'h4000, 1'b0);
        send_item(1'b1, 16'd0, 16'hffff, 1'b0);
        drain();
        // sign and magnitude, width zero
        set_all(MODE_SIGNMAG, 4'd0, 16'hfff0, 16'd10, 14'd0, 14'd0);
        send_item(1'b0, 16'hfff5, 16'd0, 1'b0);
        send_item(1'b1, 16'd0, 16'd0, 1'b0);
        send_item(1'b1, 16'd0, 16'd5, 1'b0);
        drain();
        // mode three, equal ends, reversed ends
        set_all(2'd3, 4'd7, 16'd5, 16'd5, 14'd7, 14'd3);
        send_item(1'b0, 16'd9, 16'd0, 1'b0);
        send_item(1'b1, 16'd0, 16'd5, 1'b0);
        send_item(1'b1, 16'd0, 16'd1, 1'b0);
        drain();
        set_all(MODE_LINEAR, 4'd14, 16'd100, 16'hff00, 14'h3fff, 14'd0);
        send_item(1'b0, 16'd3, 16'd0, 1'b0);
        send_item(1'b1, 16'd0, 16'd8000, 1'b0);
        drain();

        // random phases over several settings
        sink_gaps = 1'b1;
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: set_all(MODE_LINEAR, 4'($urandom_range(1, 14)), 16'($urandom),
                           16'($urandom), 14'($urandom), 14'($urandom));
                1: set_all(MODE_TWOS, 4'($urandom_range(0, 15)),
                           16'($urandom_range(0, 255) - 300), 16'($urandom_range(0, 400)),
                           14'($urandom), 14'($urandom));
                2: set_all(MODE_SIGNMAG, 4'($urandom_range(0, 15)), 16'h8000, 16'h7fff,
                           14'($urandom), 14'($urandom));
                default: set_all(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                 16'($urandom_range(0, 200) - 100),
                                 16'($urandom_range(0, 2000)),
                                 14'($urandom_range(0, 50)), 14'($urandom_range(0, 16383)));
            endcase
            if (ph == 5) hold_off = 1'b1;
            for (int k = 0; k < N_RANDOM / 16; k++) send_random(ph % 3 != 2);
            drain();
        end

        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/mvsc_pkg.sv
hw/rtl/mvsc_div_cell.sv
hw/rtl/midi_value_sign_converter_unit.sv
hw/rtl/mvsc_checker.sv
dv/midi_value_sign_converter_unit_tb.sv
